/* rtl/core/nipd_pkg.sv */
// ----------------------------------------------------------------------------
// nipd_pkg: shared types and constants of the NEC IR pulse decoder
// Holds the pulse classification word, the decode phases, the result status
// codes, the register indexes and the field widths used across the block.
// ----------------------------------------------------------------------------
package nipd_pkg;

   // Frame and field sizes.
   localparam int FRAME_BITS      = 32;
   localparam int BIT_COUNT_WIDTH = $clog2(FRAME_BITS);
   localparam int BASE_WIDTH      = 11;
   localparam int WIDTH_US_BITS   = 16;
   localparam int REQ_TDATA_WIDTH = 24;
   localparam int RSP_TDATA_WIDTH = 48;
   localparam int WINDOW_WIDTH    = WIDTH_US_BITS + 1;

   localparam logic [BASE_WIDTH-1:0] BASE_UNIT_RESET = 11'd563;
   localparam logic [BIT_COUNT_WIDTH-1:0] LAST_BIT_INDEX = BIT_COUNT_WIDTH'(FRAME_BITS - 1);
   localparam logic [7:0] BYTE_MASK = 8'hff;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_BASE_UNIT  = 1'b0,
      CSR_CHECK_ADDR = 1'b1
   } csr_index_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_DATA   = 2'd0,
      STATUS_REPEAT = 2'd1,
      STATUS_ERROR  = 2'd2,
      STATUS_NOLEAD = 2'd3
   } frame_status_type;

   // Decode phases, one-hot.
   typedef enum logic [3:0] {
      PHASE_IDLE      = 4'b0001,
      PHASE_LEADER    = 4'b0010,
      PHASE_BIT_LOW   = 4'b0100,
      PHASE_BIT_HIGH  = 4'b1000
   } phase_type;

   // One classified pulse as it travels from the front to the back.
   typedef struct packed {
      logic timeout;
      logic level;
      logic match_16;
      logic match_8;
      logic match_4;
      logic match_3;
      logic match_1;
   } pulse_class_type;

   // True when the width lies strictly inside nominal plus or minus half.
   function automatic logic in_window(input logic [WIDTH_US_BITS-1:0] width,
                                      input logic [WINDOW_WIDTH-1:0] nominal,
                                      input logic [BASE_WIDTH-2:0] half);
      logic [WINDOW_WIDTH-1:0] low_edge;
      logic [WINDOW_WIDTH-1:0] high_edge;
      logic [WINDOW_WIDTH-1:0] width_ext;
      low_edge  = nominal - WINDOW_WIDTH'(half);
      high_edge = nominal + WINDOW_WIDTH'(half);
      width_ext = WINDOW_WIDTH'(width);
      return (width_ext > low_edge) && (width_ext < high_edge);
   endfunction

endpackage

/* rtl/core/nec_ir_pulse_decoder_unit.sv */
// ----------------------------------------------------------------------------
// nec_ir_pulse_decoder_unit: NEC infrared remote decoder on measured pulses
// Each request word is one measured pulse of the IR line. The block decodes
// the NEC leader, repeat code and 32 data bits and reports one status word
// per finished frame, repeat code, error or stray pulse.
//
// Request channel: tdata carries pulse_level and pulse_width_us, tuser the
// edge_timeout flag. Response channel: tdata carries device_address,
// key_command and raw_frame, tuser the frame_status code.
// The csr port sets the base unit in microseconds and enables the address
// inverse check; write it only while no pulse is in flight.
// Throughput is one pulse per cycle while the queue is not full. A pulse is
// classified as it enters a two-entry queue; the sequencer pops it when the
// result register can take a result, and the result register drives the
// response channel. When the receiver stalls, the result register holds its
// word, the queue fills and req_tready drops once both entries are taken.
// Reset sets the base unit to 563 us, turns the address check off, empties
// the queue and returns the sequencer to waiting for a leader.
// ----------------------------------------------------------------------------
module nec_ir_pulse_decoder_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [0:0]                             csr_index,
   input  logic [nipd_pkg::BASE_WIDTH-1:0]        csr_wdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0 up: pulse_level, pulse_width_us, zero fill.
   input  logic [nipd_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   // Fields from bit 0 up: edge_timeout.
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // Fields from bit 0 up: device_address, key_command, raw_frame.
   output logic [nipd_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   // Fields from bit 0 up: frame_status.
   output logic [1:0]                             rsp_tuser
);

   logic                      queue_full;
   logic                      queue_push;
   logic                      queue_pop;
   logic                      head_valid;
   logic                      check_addr;
   nipd_pkg::pulse_class_type push_entry;
   nipd_pkg::pulse_class_type head_entry;

   // Classification front.
   nipd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_entry (push_entry),
      .check_addr  (check_addr)
   );

   // Queue between front and back.
   nipd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Frame sequencer and result register.
   nipd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .check_addr (check_addr),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .queue_pop  (queue_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* rtl/core/nipd_front.sv */
// ----------------------------------------------------------------------------
// nipd_front: configuration registers and pulse classification
// Accepts pulse words, compares the width against the five timing windows
// and pushes the resulting classification word into the queue.
// ----------------------------------------------------------------------------
module nipd_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [0:0]                             csr_index,
   input  logic [nipd_pkg::BASE_WIDTH-1:0]        csr_wdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // Fields from bit 0 up: pulse_level, pulse_width_us, zero fill.
   input  logic [nipd_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   // Fields from bit 0 up: edge_timeout.
   input  logic                                   req_tuser,
   input  logic                                   queue_full,
   output logic                                   queue_push,
   output nipd_pkg::pulse_class_type              queue_entry,
   output logic                                   check_addr
);

   logic [nipd_pkg::BASE_WIDTH-1:0] base_unit_ff;
   logic [nipd_pkg::BASE_WIDTH-1:0] base_unit_in;
   logic                            check_addr_ff;
   logic                            check_addr_in;

   logic [nipd_pkg::WIDTH_US_BITS-1:0] width_us;
   logic [nipd_pkg::BASE_WIDTH-2:0]    half_unit;
   logic [nipd_pkg::WINDOW_WIDTH-1:0]  base_ext;
   logic [nipd_pkg::WINDOW_WIDTH-1:0]  nominal_3;

   // Register writes.
   always_comb begin
      base_unit_in  = base_unit_ff;
      check_addr_in = check_addr_ff;
      if (csr_we) begin
         case (csr_index)
            nipd_pkg::CSR_BASE_UNIT:  base_unit_in  = csr_wdata;
            nipd_pkg::CSR_CHECK_ADDR: check_addr_in = csr_wdata[0];
            default: begin
               base_unit_in  = base_unit_ff;
               check_addr_in = check_addr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_unit_ff  <= nipd_pkg::BASE_UNIT_RESET;
         check_addr_ff <= 1'b0;
      end else begin
         base_unit_ff  <= base_unit_in;
         check_addr_ff <= check_addr_in;
      end
   end

   assign check_addr = check_addr_ff;

   // Window nominals are shifts of the base unit; three units is one add.
   assign width_us  = req_tdata[nipd_pkg::WIDTH_US_BITS:1];
   assign half_unit = base_unit_ff[nipd_pkg::BASE_WIDTH-1:1];
   assign base_ext  = nipd_pkg::WINDOW_WIDTH'(base_unit_ff);
   assign nominal_3 = (base_ext << 1) + base_ext;

   // Classify the pulse on its way into the queue.
   always_comb begin
      queue_entry.timeout  = req_tuser;
      queue_entry.level    = req_tdata[0];
      queue_entry.match_16 = nipd_pkg::in_window(width_us, base_ext << 4, half_unit);
      queue_entry.match_8  = nipd_pkg::in_window(width_us, base_ext << 3, half_unit);
      queue_entry.match_4  = nipd_pkg::in_window(width_us, base_ext << 2, half_unit);
      queue_entry.match_3  = nipd_pkg::in_window(width_us, nominal_3, half_unit);
      queue_entry.match_1  = nipd_pkg::in_window(width_us, base_ext, half_unit);
   end

   assign req_tready = !queue_full;
   assign queue_push = req_tvalid && !queue_full;

endmodule

/* rtl/core/nipd_queue.sv */
// ----------------------------------------------------------------------------
// nipd_queue: two-entry queue of classified pulses
// Decouples the classification front from the decode back so that each
// side can stall on its own without losing a word.
// ----------------------------------------------------------------------------
module nipd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  nipd_pkg::pulse_class_type  push_entry,
   output logic                       full,
   input  logic                       pop,
   output logic                       head_valid,
   output nipd_pkg::pulse_class_type  head_entry
);

   nipd_pkg::pulse_class_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = count_ff[1];
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = entry_ff[rd_ptr_ff];

endmodule

/* rtl/core/nipd_back.sv */
// ----------------------------------------------------------------------------
// nipd_back: NEC frame sequencer and result register
// Walks the leader, repeat and data bit phases on classified pulses,
// checks the inverted byte copies and holds each result word for the sink.
// ----------------------------------------------------------------------------
module nipd_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   check_addr,
   input  logic                                   head_valid,
   input  nipd_pkg::pulse_class_type              head_entry,
   output logic                                   queue_pop,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // Fields from bit 0 up: device_address, key_command, raw_frame.
   output logic [nipd_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   // Fields from bit 0 up: frame_status.
   output logic [1:0]                             rsp_tuser
);

   nipd_pkg::phase_type                    phase_ff;
   nipd_pkg::phase_type                    phase_in;
   logic [nipd_pkg::BIT_COUNT_WIDTH-1:0]   bits_ff;
   logic [nipd_pkg::BIT_COUNT_WIDTH-1:0]   bits_in;
   logic [nipd_pkg::FRAME_BITS-1:0]        shift_ff;
   logic [nipd_pkg::FRAME_BITS-1:0]        shift_in;

   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic [nipd_pkg::RSP_TDATA_WIDTH-1:0]   rsp_data_ff;
   logic [1:0]                             rsp_status_ff;

   logic                                   emit;
   nipd_pkg::frame_status_type             status;
   logic [7:0]                             out_addr;
   logic [7:0]                             out_cmd;
   logic [nipd_pkg::FRAME_BITS-1:0]        out_raw;
   logic [nipd_pkg::FRAME_BITS-1:0]        raw_new;
   logic                                   addr_bad;
   logic                                   cmd_bad;

   // A word leaves the queue whenever the result register can take a result.
   assign queue_pop = head_valid && (!rsp_valid_ff || rsp_tready);

   // The bit that just arrived, merged into the frame.
   always_comb begin
      raw_new = shift_ff;
      if (head_entry.match_3) begin
         raw_new = shift_ff | (nipd_pkg::FRAME_BITS'(1) << bits_ff);
      end
      addr_bad = check_addr && (raw_new[7:0] != (~raw_new[15:8] & nipd_pkg::BYTE_MASK));
      cmd_bad  = raw_new[23:16] != (~raw_new[31:24] & nipd_pkg::BYTE_MASK);
   end

   // Phase sequencer.
   always_comb begin
      phase_in = phase_ff;
      bits_in  = bits_ff;
      shift_in = shift_ff;
      emit     = 1'b0;
      status   = nipd_pkg::STATUS_ERROR;
      out_addr = 8'd0;
      out_cmd  = 8'd0;
      out_raw  = '0;
      if (queue_pop) begin
         case (phase_ff)
            nipd_pkg::PHASE_IDLE: begin
               if (!head_entry.timeout) begin
                  if (!head_entry.level && head_entry.match_16) begin
                     phase_in = nipd_pkg::PHASE_LEADER;
                  end else begin
                     emit   = 1'b1;
                     status = nipd_pkg::STATUS_NOLEAD;
                  end
               end
            end
            nipd_pkg::PHASE_LEADER: begin
               if (head_entry.timeout) begin
                  phase_in = nipd_pkg::PHASE_IDLE;
               end else if (head_entry.level && head_entry.match_8) begin
                  phase_in = nipd_pkg::PHASE_BIT_LOW;
                  bits_in  = '0;
                  shift_in = '0;
               end else if (head_entry.level && head_entry.match_4) begin
                  phase_in = nipd_pkg::PHASE_IDLE;
                  emit     = 1'b1;
                  status   = nipd_pkg::STATUS_REPEAT;
               end else begin
                  phase_in = nipd_pkg::PHASE_IDLE;
                  emit     = 1'b1;
               end
            end
            nipd_pkg::PHASE_BIT_LOW: begin
               if (head_entry.timeout || head_entry.level || !head_entry.match_1) begin
                  phase_in = nipd_pkg::PHASE_IDLE;
                  emit     = 1'b1;
               end else begin
                  phase_in = nipd_pkg::PHASE_BIT_HIGH;
               end
            end
            nipd_pkg::PHASE_BIT_HIGH: begin
               if (head_entry.timeout || !head_entry.level ||
                   (!head_entry.match_3 && !head_entry.match_1)) begin
                  phase_in = nipd_pkg::PHASE_IDLE;
                  emit     = 1'b1;
               end else begin
                  shift_in = raw_new;
                  if (bits_ff != nipd_pkg::LAST_BIT_INDEX) begin
                     bits_in  = bits_ff + 1'b1;
                     phase_in = nipd_pkg::PHASE_BIT_LOW;
                  end else begin
                     // Frame complete: check the inverted copies.
                     bits_in  = '0;
                     phase_in = nipd_pkg::PHASE_IDLE;
                     emit     = 1'b1;
                     if (!addr_bad && !cmd_bad) begin
                        status   = nipd_pkg::STATUS_DATA;
                        out_addr = raw_new[7:0];
                        out_cmd  = raw_new[23:16];
                        out_raw  = raw_new;
                     end
                  end
               end
            end
            default: begin
               phase_in = nipd_pkg::PHASE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= nipd_pkg::PHASE_IDLE;
         bits_ff  <= '0;
         shift_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
      end
   end

   // Result register: loads when empty or in the cycle the old word is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (queue_pop && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop && emit) begin
         rsp_data_ff   <= {out_raw, out_cmd, out_addr};
         rsp_status_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the NEC IR pulse decoder unit
// Streams measured pulses into the decoder: clean frames, repeat codes, broken
// frames and noise, over several base units with the address check on and
// off. A behavioral decoder inside the bench predicts each status word, and
// every word on the response channel is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   import nipd_pkg::*;

   localparam int CYCLE_LIMIT       = 300000;
   localparam int SETTLE_CYCLES     = 8;
   localparam int MAX_SHOWN         = 10;
   localparam int RESET_UNIT        = int'(BASE_UNIT_RESET);
   localparam int RESET_HALF        = RESET_UNIT / 2;

   // One decoded report as the response channel carries it.
   typedef struct packed {
      frame_status_type status;
      logic [7:0]       address;
      logic [7:0]       command;
      logic [31:0]      raw;
   } ir_report_type;

   // Ways to break a frame part way through.
   typedef enum int {
      CUT_TIMEOUT,
      CUT_LEVEL,
      CUT_WIDTH
   } frame_cut_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [0:0]                 csr_index;
   logic [BASE_WIDTH-1:0]      csr_wdata;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;
   logic                       req_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic [1:0]                 rsp_tuser;

   // Decoder state tracked by the bench.
   logic [BASE_WIDTH-1:0]      unit_us;
   logic                       check_address;
   phase_type                  phase;
   int                         bits_seen;
   logic [31:0]                bit_shift;

   ir_report_type              reports_due[$];
   int                         pulses_sent;
   int                         mismatches;
   int                         cycle_count;
   bit                         tx_steady;
   bit                         rx_steady;

   nec_ir_pulse_decoder_unit uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Strict window test: nominal minus half < width < nominal plus half.
   function automatic bit fits_window(input logic [15:0] width, input int units);
      int nominal;
      int half;
      nominal = units * int'(unit_us);
      half    = int'(unit_us) >> 1;
      return (int'(width) > nominal - half) && (int'(width) < nominal + half);
   endfunction

   // A random width inside the window of the given number of units.
   function automatic logic [15:0] window_width(input int units);
      int half;
      half = int'(unit_us) >> 1;
      if (half == 0)
         return 16'(units * int'(unit_us));
      return 16'(units * int'(unit_us) + int'($urandom_range(0, 2 * half - 2)) - (half - 1));
   endfunction

   // Advances the tracked decoder by one pulse; returns 1 when a report is due.
   function automatic bit decode_pulse(input logic level, input logic [15:0] width,
                                       input logic no_edge, output ir_report_type report);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      report = '0;
      report.status = STATUS_ERROR;
      case (phase)
         PHASE_IDLE: begin
            if (no_edge)
               return 1'b0;
            if (!level && fits_window(width, 16)) begin
               phase = PHASE_LEADER;
               return 1'b0;
            end
            report.status = STATUS_NOLEAD;
            return 1'b1;
         end
         PHASE_LEADER: begin
            if (no_edge) begin
               phase = PHASE_IDLE;
               return 1'b0;
            end
            if (level && fits_window(width, 8)) begin
               phase     = PHASE_BIT_LOW;
               bits_seen = 0;
               bit_shift = '0;
               return 1'b0;
            end
            phase = PHASE_IDLE;
            if (level && fits_window(width, 4))
               report.status = STATUS_REPEAT;
            return 1'b1;
         end
         PHASE_BIT_LOW: begin
            if (no_edge || level || !fits_window(width, 1)) begin
               phase = PHASE_IDLE;
               return 1'b1;
            end
            phase = PHASE_BIT_HIGH;
            return 1'b0;
         end
         default: begin
            if (no_edge || !level) begin
               phase = PHASE_IDLE;
               return 1'b1;
            end
            if (fits_window(width, 3)) begin
               bit_shift[bits_seen % 32] = 1'b1;
            end else if (!fits_window(width, 1)) begin
               phase = PHASE_IDLE;
               return 1'b1;
            end
            bits_seen = bits_seen + 1;
            if (bits_seen < FRAME_BITS) begin
               phase = PHASE_BIT_LOW;
               return 1'b0;
            end
            // Full frame in: apply the inverse-copy checks.
            bits_seen = 0;
            phase     = PHASE_IDLE;
            {b3, b2, b1, b0} = bit_shift;
            if ((check_address && b0 != ~b1) || b2 != ~b3)
               return 1'b1;
            report.status  = STATUS_DATA;
            report.address = b0;
            report.command = b2;
            report.raw     = bit_shift;
            return 1'b1;
         end
      endcase
   endfunction

   // Offers one pulse word after a random gap and waits until it is taken.
   task automatic send_pulse(input logic level, input logic [15:0] width, input logic no_edge);
      int gap;
      ir_report_type report;
      gap = tx_steady ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_WIDTH'({width, level});
      req_tuser  <= no_edge;
      do @(posedge clock); while (!req_tready);
      pulses_sent++;
      if (decode_pulse(level, width, no_edge, report))
         reports_due.push_back(report);
   endtask

   // Holds the sender back until every predicted report has come out.
   task automatic drain_reports();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (reports_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write, only once the decoder has gone quiet.
   task automatic write_reg(input csr_index_type index, input int value);
      drain_reports();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= BASE_WIDTH'(value);
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == CSR_BASE_UNIT)
         unit_us = BASE_WIDTH'(value);
      else
         check_address = value[0];
   endtask

   // Leader, header and 32 bits LSB first; cut_at picks a bit pulse to spoil.
   task automatic send_frame(input logic [31:0] raw, input int cut_at, input frame_cut_type cut);
      int k;
      logic lvl;
      logic [15:0] w;
      send_pulse(1'b0, window_width(16), 1'b0);
      send_pulse(1'b1, window_width(8), 1'b0);
      for (k = 0; k < 2 * FRAME_BITS; k++) begin
         lvl = (k % 2) != 0;
         w   = (lvl && raw[k / 2]) ? window_width(3) : window_width(1);
         if (k == cut_at) begin
            case (cut)
               CUT_TIMEOUT: send_pulse(lvl, w, 1'b1);
               CUT_LEVEL:   send_pulse(!lvl, w, 1'b0);
               default:     send_pulse(lvl, 16'(2 * int'(unit_us)), 1'b0);
            endcase
            return;
         end
         send_pulse(lvl, w, 1'b0);
      end
   endtask

   // Window edges and exits from the leader and bit phases.
   task automatic test_pulse_rules();
      send_pulse(1'b1, 16'hffff, 1'b1);
      send_pulse(1'b1, 16'(16 * RESET_UNIT), 1'b0);
      send_pulse(1'b0, 16'h0000, 1'b0);
      send_pulse(1'b0, 16'hffff, 1'b0);
      send_pulse(1'b0, 16'(16 * RESET_UNIT - RESET_HALF), 1'b0);
      send_pulse(1'b0, 16'(16 * RESET_UNIT + RESET_HALF), 1'b0);
      // Leader just inside the lower edge, then no edge in time.
      send_pulse(1'b0, 16'(16 * RESET_UNIT - RESET_HALF + 1), 1'b0);
      send_pulse(1'b0, 16'h0000, 1'b1);
      // Leader just inside the upper edge, then a pulse that fits nothing.
      send_pulse(1'b0, 16'(16 * RESET_UNIT + RESET_HALF - 1), 1'b0);
      send_pulse(1'b1, 16'hffff, 1'b0);
      // Repeat code.
      send_pulse(1'b0, 16'(16 * RESET_UNIT), 1'b0);
      send_pulse(1'b1, 16'(4 * RESET_UNIT), 1'b0);
      // Header with the wrong level.
      send_pulse(1'b0, 16'(16 * RESET_UNIT), 1'b0);
      send_pulse(1'b0, 16'(8 * RESET_UNIT), 1'b0);
      // Timeout where a bit should start.
      send_pulse(1'b0, 16'(16 * RESET_UNIT), 1'b0);
      send_pulse(1'b1, 16'(8 * RESET_UNIT), 1'b0);
      send_pulse(1'b0, 16'h0000, 1'b1);
      // High level where a bit should start low.
      send_pulse(1'b0, 16'(16 * RESET_UNIT), 1'b0);
      send_pulse(1'b1, 16'(8 * RESET_UNIT), 1'b0);
      send_pulse(1'b1, 16'(RESET_UNIT), 1'b0);
      // Bit high pulse between the one-unit and three-unit windows.
      send_pulse(1'b0, 16'(16 * RESET_UNIT), 1'b0);
      send_pulse(1'b1, 16'(8 * RESET_UNIT), 1'b0);
      send_pulse(1'b0, 16'(RESET_UNIT), 1'b0);
      send_pulse(1'b1, 16'(2 * RESET_UNIT), 1'b0);
      // Timeout in the middle of a bit.
      send_pulse(1'b0, 16'(16 * RESET_UNIT), 1'b0);
      send_pulse(1'b1, 16'(8 * RESET_UNIT), 1'b0);
      send_pulse(1'b0, 16'(RESET_UNIT), 1'b0);
      send_pulse(1'b1, 16'h0000, 1'b1);
   endtask

   // Command inverse always checked, address inverse only when enabled.
   task automatic test_frame_checks();
      write_reg(CSR_CHECK_ADDR, 0);
      send_frame(32'hff00_1234, -1, CUT_TIMEOUT);
      send_frame(32'hffff_ffff, -1, CUT_TIMEOUT);
      write_reg(CSR_CHECK_ADDR, 1);
      send_frame(32'hff00_1234, -1, CUT_TIMEOUT);
      send_frame(32'h00ff_cb34, -1, CUT_TIMEOUT);
   endtask

   // Random mix of clean frames, broken frames, repeat codes and noise.
   task automatic test_random_traffic(input int unit, input int check, input int pulse_goal);
      int first;
      int pick;
      logic [7:0] address;
      logic [7:0] command;
      logic [7:0] address_copy;
      logic [31:0] raw;
      int units;
      write_reg(CSR_BASE_UNIT, unit);
      write_reg(CSR_CHECK_ADDR, check);
      first = pulses_sent;
      while (pulses_sent - first < pulse_goal) begin
         tx_steady = ($urandom_range(0, 3) == 0);
         rx_steady = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            address      = 8'($urandom);
            command      = 8'($urandom);
            address_copy = $urandom_range(0, 1) ? ~address : 8'($urandom);
            raw          = {~command, command, address_copy, address};
            if ($urandom_range(0, 6) == 0)
               raw = $urandom;
            send_frame(raw, -1, CUT_TIMEOUT);
         end else if (pick < 55) begin
            send_frame($urandom, $urandom_range(0, 2 * FRAME_BITS - 1),
                       frame_cut_type'($urandom_range(0, 2)));
         end else if (pick < 75) begin
            send_pulse(1'b0, window_width(16), 1'b0);
            send_pulse(1'b1, window_width(4), 1'b0);
         end else if (pick < 97) begin
            case ($urandom_range(0, 4))
               0: units = 1;
               1: units = 3;
               2: units = 4;
               3: units = 8;
               default: units = 16;
            endcase
            send_pulse(1'($urandom_range(0, 1)),
                       $urandom_range(0, 1) ? 16'($urandom) : window_width(units),
                       $urandom_range(0, 4) == 0);
         end else begin
            drain_reports();
         end
      end
   endtask

   // Each response word is checked against the oldest prediction.
   always @(posedge clock) begin
      ir_report_type seen;
      ir_report_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.status  = frame_status_type'(rsp_tuser);
         seen.address = rsp_tdata[7:0];
         seen.command = rsp_tdata[15:8];
         seen.raw     = rsp_tdata[47:16];
         if (reports_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected word: status %0d address %h command %h raw %h",
                        seen.status, seen.address, seen.command, seen.raw);
         end else begin
            due = reports_due.pop_front();
            if (seen.status !== due.status || seen.address !== due.address ||
                seen.command !== due.command || seen.raw !== due.raw) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN) begin
                  $display("mismatch: expected status %0d address %h command %h raw %h",
                           due.status, due.address, due.command, due.raw);
                  $display("          got status %0d address %h command %h raw %h",
                           seen.status, seen.address, seen.command, seen.raw);
               end
            end
         end
      end
   end

   // Receiver: random stall before taking each word.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = rx_steady ? 0 : $urandom_range(0, 9);
         @(negedge clock);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = CSR_BASE_UNIT;
      csr_wdata     = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      tx_steady     = 1'b0;
      rx_steady     = 1'b0;
      pulses_sent   = 0;
      mismatches    = 0;
      cycle_count   = 0;
      unit_us       = BASE_UNIT_RESET;
      check_address = 1'b0;
      phase         = PHASE_IDLE;
      bits_seen     = 0;
      bit_shift     = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_pulse_rules();
      test_frame_checks();
      test_random_traffic(RESET_UNIT, 0, 150);
      test_random_traffic(100, 1, 100);
      test_random_traffic(2000, 0, 100);
      test_random_traffic(2047, 1, 80);
      // Base units too small to open any window.
      test_random_traffic(1, 0, 40);
      test_random_traffic(0, 1, 40);
      test_random_traffic($urandom_range(100, 2000), $urandom_range(0, 1), 60);
      test_random_traffic($urandom_range(100, 2000), $urandom_range(0, 1), 60);
      drain_reports();

      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
